FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros on clk with asynchronous active-low reset rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds on every clock outside reset
`define SPC_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define SPC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define SPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/spc_pkg.sv
// ----------------------------------------------------------------------------
// spc_pkg
// Shared types and constants of the servo PWM controller.
// ----------------------------------------------------------------------------
package spc_pkg;

    localparam int NUM_CHANNELS_DEF = 6;
    localparam int LINE_WIDTH       = 6;
    localparam int PULSE_W          = 16;
    localparam int PERIOD_W         = 17;

    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_PULSE = 2'd1;
    localparam logic [1:0] FUNC_ANGLE = 2'd2;
    localparam logic [1:0] FUNC_CLAMP = 2'd3;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_NOT_INIT    = 2'd1;
    localparam logic [1:0] ST_BAD_PULSE   = 2'd2;
    localparam logic [1:0] ST_BAD_CHANNEL = 2'd3;

    localparam logic [2:0] CFG_ENABLE = 3'd0;
    localparam logic [2:0] CFG_PERIOD = 3'd1;
    localparam logic [2:0] CFG_MIN    = 3'd2;
    localparam logic [2:0] CFG_MAX    = 3'd3;
    localparam logic [2:0] CFG_CENTER = 3'd4;

    localparam logic [PERIOD_W-1:0] PERIOD_RST = 17'd20000;
    localparam logic [PULSE_W-1:0]  MIN_RST    = 16'd1000;
    localparam logic [PULSE_W-1:0]  MAX_RST    = 16'd2000;
    localparam logic [PULSE_W-1:0]  CENTER_RST = 16'd1500;

    localparam logic [7:0] ANGLE_FULL = 8'd180;

    // divide by 180 as (x >> 2) / 45, with 45 done by a reciprocal exact below 2^22
    localparam int         RECIP_SHIFT = 28;
    localparam logic [22:0] RECIP_45   = 23'd5965233;

    typedef struct packed {
        logic [1:0]         func;
        logic [2:0]         channel;
        logic [PULSE_W-1:0] pulse_width;
        logic [7:0]         angle;
    } spc_item_t;

endpackage

FILE: hdl/spc_angle_scale.sv
// ----------------------------------------------------------------------------
// spc_angle_scale
// Two-stage angle to pulse offset: angle times span, then divide by 180.
// ----------------------------------------------------------------------------
module spc_angle_scale (
    input  logic                         clk,
    input  logic                         advance,
    input  logic [7:0]                   angle,
    input  logic [spc_pkg::PULSE_W-1:0]  pulse_min,
    input  logic [spc_pkg::PULSE_W-1:0]  pulse_max,
    output logic [spc_pkg::PULSE_W-1:0]  offset
);
    import spc_pkg::*;

    logic [7:0]         angle_clamped;
    logic [PULSE_W-1:0] span;
    logic [23:0]        product_next;
    logic [23:0]        product_reg;
    logic [44:0]        scaled;
    logic [PULSE_W-1:0] offset_reg;

    assign angle_clamped = (angle > ANGLE_FULL) ? ANGLE_FULL : angle;
    assign span          = (pulse_max >= pulse_min) ? (pulse_max - pulse_min) : '0;
    assign product_next  = 24'(angle_clamped) * 24'(span);
    assign scaled        = 45'(product_reg[23:2]) * 45'(RECIP_45);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            product_reg <= product_next;
            offset_reg  <= scaled[RECIP_SHIFT+PULSE_W-1:RECIP_SHIFT];
        end
    end

    assign offset = offset_reg;

endmodule

FILE: hdl/servo_pwm_controller_unit.sv
// ----------------------------------------------------------------------------
// servo_pwm_controller_unit
// Servo PWM generator: shared tick counter, per-channel compares, write checks.
// ----------------------------------------------------------------------------
// One request is accepted every clock while the result is not stalled; it passes
// the input register, angle product, divide by 180 and channel state update into
// the result register. Requests change state only in the channel state stage,
// so requests stream back to back. A stalled result holds the whole pipeline.
// Configuration writes are taken every cycle while no request is in flight.
module servo_pwm_controller_unit #(
    parameter int NUM_CHANNELS = spc_pkg::NUM_CHANNELS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     func,
    input  logic [2:0]                     channel,
    input  logic [spc_pkg::PULSE_W-1:0]    pulse_width,
    input  logic [7:0]                     angle,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [1:0]                     status,
    output logic [spc_pkg::LINE_WIDTH-1:0] pwm_lines,
    output logic                           running,
    output logic [spc_pkg::PULSE_W-1:0]    applied_pulse,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [2:0]                     cfg_index,
    input  logic [spc_pkg::PERIOD_W-1:0]   cfg_data
);
    import spc_pkg::*;

`include "assert_macros.svh"

    localparam int LINE_COUNT = (NUM_CHANNELS < LINE_WIDTH) ? NUM_CHANNELS : LINE_WIDTH;

    logic advance;
    logic cfg_fire;
    logic s3_fire;

    logic       s1_valid_reg, s2_valid_reg, s3_valid_reg;
    spc_item_t  s1_item_reg, s2_item_reg, s3_item_reg;

    logic                enable_reg, enable_next;
    logic [PERIOD_W-1:0] period_reg, period_next;
    logic [PULSE_W-1:0]  min_reg, min_next;
    logic [PULSE_W-1:0]  max_reg, max_next;
    logic [PULSE_W-1:0]  center_reg, center_next;
    logic [PULSE_W-1:0]  tick_count_reg, tick_count_next;
    logic [PULSE_W-1:0]  pending_reg [NUM_CHANNELS];
    logic [PULSE_W-1:0]  pending_next [NUM_CHANNELS];
    logic [PULSE_W-1:0]  active_reg [NUM_CHANNELS];
    logic [PULSE_W-1:0]  active_next [NUM_CHANNELS];

    logic                  out_valid_reg;
    logic [1:0]            status_reg, status_next;
    logic [LINE_WIDTH-1:0] lines_reg, lines_next;
    logic                  running_reg;
    logic [PULSE_W-1:0]    applied_reg, applied_next;

    logic [PULSE_W-1:0]  angle_offset;
    logic [PULSE_W-1:0]  pulse_sel;
    logic [PERIOD_W-1:0] top_wide;
    logic [PULSE_W-1:0]  top;
    logic                is_write;
    logic                in_range;
    logic                channel_ok;
    logic                write_ok;

    assign advance   = !out_valid_reg || out_ready;
    assign in_ready  = advance;
    assign cfg_ready = !(s1_valid_reg || s2_valid_reg || s3_valid_reg);
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign s3_fire   = advance && s3_valid_reg;

    spc_angle_scale u_angle_scale (
        .clk       (clk),
        .advance   (advance),
        .angle     (s1_item_reg.angle),
        .pulse_min (min_reg),
        .pulse_max (max_reg),
        .offset    (angle_offset)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_item_reg <= '{func: func, channel: channel, pulse_width: pulse_width,
                             angle: angle};
            s2_item_reg <= s1_item_reg;
            s3_item_reg <= s2_item_reg;
        end
    end

    always_comb
    begin
        case (s3_item_reg.func)
            FUNC_PULSE: pulse_sel = s3_item_reg.pulse_width;
            FUNC_ANGLE: pulse_sel = (max_reg >= min_reg) ? (min_reg + angle_offset) : min_reg;
            FUNC_CLAMP:
            begin
                if (s3_item_reg.pulse_width < min_reg)
                    pulse_sel = min_reg;
                else if (s3_item_reg.pulse_width > max_reg)
                    pulse_sel = max_reg;
                else
                    pulse_sel = s3_item_reg.pulse_width;
            end
            default: pulse_sel = s3_item_reg.pulse_width;
        endcase
    end

    assign is_write   = s3_item_reg.func != FUNC_TICK;
    assign in_range   = (pulse_sel >= min_reg) && (pulse_sel <= max_reg);
    assign channel_ok = {1'b0, s3_item_reg.channel} < 4'(NUM_CHANNELS);
    assign write_ok   = is_write && enable_reg && in_range && channel_ok;
    assign top_wide   = (period_reg == '0) ? '0 : (period_reg - 1'b1);
    assign top        = top_wide[PERIOD_W-1] ? '1 : top_wide[PULSE_W-1:0];

    always_comb
    begin
        enable_next     = enable_reg;
        period_next     = period_reg;
        min_next        = min_reg;
        max_next        = max_reg;
        center_next     = center_reg;
        tick_count_next = tick_count_reg;
        pending_next    = pending_reg;
        active_next     = active_reg;
        if (cfg_fire)
        begin
            case (cfg_index)
                CFG_ENABLE:
                begin
                    if (cfg_data[0] && !enable_reg)
                    begin
                        tick_count_next = '0;
                        for (int c = 0; c < NUM_CHANNELS; c++)
                        begin
                            pending_next[c] = center_reg;
                            active_next[c]  = center_reg;
                        end
                    end
                    enable_next = cfg_data[0];
                end
                CFG_PERIOD: period_next = cfg_data;
                CFG_MIN:    min_next    = cfg_data[PULSE_W-1:0];
                CFG_MAX:    max_next    = cfg_data[PULSE_W-1:0];
                CFG_CENTER: center_next = cfg_data[PULSE_W-1:0];
                default: ;
            endcase
        end
        else if (s3_fire)
        begin
            if (!is_write && enable_reg)
            begin
                if (tick_count_reg >= top)
                begin
                    tick_count_next = '0;
                    active_next     = pending_reg;
                end
                else
                begin
                    tick_count_next = tick_count_reg + 1'b1;
                end
            end
            if (write_ok)
            begin
                for (int c = 0; c < NUM_CHANNELS; c++)
                begin
                    if (s3_item_reg.channel == 3'(c))
                        pending_next[c] = pulse_sel;
                end
            end
        end
    end

    always_comb
    begin
        if (!is_write)
            status_next = ST_OK;
        else if (!enable_reg)
            status_next = ST_NOT_INIT;
        else if (!in_range)
            status_next = ST_BAD_PULSE;
        else if (!channel_ok)
            status_next = ST_BAD_CHANNEL;
        else
            status_next = ST_OK;
        applied_next = write_ok ? pulse_sel : '0;
        lines_next   = '0;
        for (int c = 0; c < LINE_COUNT; c++)
        begin
            lines_next[c] = enable_reg && (tick_count_next < active_next[c]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg     <= 1'b0;
            period_reg     <= PERIOD_RST;
            min_reg        <= MIN_RST;
            max_reg        <= MAX_RST;
            center_reg     <= CENTER_RST;
            tick_count_reg <= '0;
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                pending_reg[c] <= CENTER_RST;
                active_reg[c]  <= CENTER_RST;
            end
        end
        else
        begin
            enable_reg     <= enable_next;
            period_reg     <= period_next;
            min_reg        <= min_next;
            max_reg        <= max_next;
            center_reg     <= center_next;
            tick_count_reg <= tick_count_next;
            pending_reg    <= pending_next;
            active_reg     <= active_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s3_fire)
        begin
            status_reg  <= status_next;
            lines_reg   <= lines_next;
            running_reg <= enable_reg;
            applied_reg <= applied_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign pwm_lines     = lines_reg;
    assign running       = running_reg;
    assign applied_pulse = applied_reg;

    `SPC_ASSERT_SAME(a_idle_lines_low, out_valid_reg && !running_reg, lines_reg == '0, "lines high while disabled")
    `SPC_ASSERT_SAME(a_reject_no_pulse, out_valid_reg && (status_reg != ST_OK), applied_reg == '0, "rejected request reports a pulse")
    `SPC_ASSERT_NEXT(a_enable_clears, cfg_fire && (cfg_index == CFG_ENABLE) && cfg_data[0] && !enable_reg, enable_reg && (tick_count_reg == '0), "enable did not clear counter")

endmodule
